// ===== sv/ppd_pkg.sv =====
// Package for the pinhole projection block with lens distortion.
// Holds register indexes, fixed-point constants and the pipeline side-band type.
// No dependencies.
package ppd_pkg;

	localparam int FRAC_BITS = 28;
	localparam int DIV_BITS  = 30;
	localparam int LATENCY   = DIV_BITS + 11;

	localparam logic [29:0]        NORM_LIM  = 30'd536870912;
	localparam logic signed [40:0] ONE_Q28   = 41'sd268435456;
	localparam logic signed [31:0] SAT_MAX   = 32'sh7FFFFFFF;
	localparam logic signed [31:0] SAT_MIN   = 32'sh80000000;

	localparam logic [30:0] FOCAL_RESET    = 31'd32768000;
	localparam logic [31:0] CENTER_X_RESET = 32'd20971520;
	localparam logic [31:0] CENTER_Y_RESET = 32'd15728640;

	typedef enum logic [2:0] {
		CFG_FOCAL_X      = 3'd0,
		CFG_FOCAL_Y      = 3'd1,
		CFG_CENTER_X     = 3'd2,
		CFG_CENTER_Y     = 3'd3,
		CFG_RADIAL_A     = 3'd4,
		CFG_RADIAL_B     = 3'd5,
		CFG_TANGENTIAL_A = 3'd6,
		CFG_TANGENTIAL_B = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic last;
		logic zero;
		logic neg_x;
		logic neg_y;
		logic ovf_x;
		logic ovf_y;
	} side_t;

endpackage

// ===== sv/pinhole_project_distort.sv =====
// Pinhole projection with radial and tangential distortion, fully pipelined.
// Depends on ppd_pkg.
//
//  channel   handshake          payload
//  input     start / busy       point_x, point_y, point_z, point_last
//  result    done (strobe)      pixel_u, pixel_v, depth_zero, result_last
//  config    cfg_we             cfg_index, cfg_data
//
// One point per cycle; results come out in the order the points went in.
// The pipeline is the 30-step restoring divider (one quotient bit a stage)
// plus eleven stages of sign handling, multiplies and saturation.
// busy stays low: the pipeline always advances, so nothing stalls or repeats.
// arst_n clears the valid bits and loads the register reset values.
module pinhole_project_distort (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic signed [31:0]     point_x,
	input  logic signed [31:0]     point_y,
	input  logic signed [31:0]     point_z,
	input  logic                   point_last,
	input  logic                   cfg_we,
	input  ppd_pkg::cfg_reg_t      cfg_index,
	input  logic [31:0]            cfg_data,
	output logic                   done,
	output logic signed [31:0]     pixel_u,
	output logic signed [31:0]     pixel_v,
	output logic                   depth_zero,
	output logic                   result_last
);
	import ppd_pkg::*;

	logic [30:0]        focal_x_q, focal_y_q;
	logic signed [31:0] center_x_q, center_y_q;
	logic signed [31:0] radial_a_q, radial_b_q, tang_a_q, tang_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q  <= FOCAL_RESET;
			focal_y_q  <= FOCAL_RESET;
			center_x_q <= $signed(CENTER_X_RESET);
			center_y_q <= $signed(CENTER_Y_RESET);
			radial_a_q <= '0;
			radial_b_q <= '0;
			tang_a_q   <= '0;
			tang_b_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FOCAL_X:      focal_x_q  <= cfg_data[30:0];
				CFG_FOCAL_Y:      focal_y_q  <= cfg_data[30:0];
				CFG_CENTER_X:     center_x_q <= $signed(cfg_data);
				CFG_CENTER_Y:     center_y_q <= $signed(cfg_data);
				CFG_RADIAL_A:     radial_a_q <= $signed(cfg_data);
				CFG_RADIAL_B:     radial_b_q <= $signed(cfg_data);
				CFG_TANGENTIAL_A: tang_a_q   <= $signed(cfg_data);
				CFG_TANGENTIAL_B: tang_b_q   <= $signed(cfg_data);
				default:          ;
			endcase
		end
	end

	assign busy = 1'b0;

	// stage 0: magnitudes, signs, range check
	logic [31:0] ax, ay, az;
	logic        accept;
	assign accept = start && !busy;
	assign ax = point_x[31] ? (~point_x + 32'd1) : point_x;
	assign ay = point_y[31] ? (~point_y + 32'd1) : point_y;
	assign az = point_z[31] ? (~point_z + 32'd1) : point_z;

	logic        v_s0;
	side_t       side_s0;
	logic [31:0] ax_s0, ay_s0, az_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else begin
			v_s0 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		side_s0.last  <= point_last;
		side_s0.zero  <= (point_z == 32'sd0);
		side_s0.neg_x <= point_x[31] ^ point_z[31];
		side_s0.neg_y <= point_y[31] ^ point_z[31];
		side_s0.ovf_x <= {2'b00, ax} >= {az, 2'b00};
		side_s0.ovf_y <= {2'b00, ay} >= {az, 2'b00};
		ax_s0 <= ax;
		ay_s0 <= ay;
		az_s0 <= az;
	end

	// divider: one quotient bit per stage
	logic              v_sd    [0:DIV_BITS];
	side_t             side_sd [0:DIV_BITS];
	logic [31:0]       az_sd   [0:DIV_BITS];
	logic [31:0]       rx_sd   [0:DIV_BITS];
	logic [31:0]       ry_sd   [0:DIV_BITS];
	logic [DIV_BITS-1:0] nbx_sd [0:DIV_BITS];
	logic [DIV_BITS-1:0] nby_sd [0:DIV_BITS];
	logic [DIV_BITS-1:0] qx_sd  [0:DIV_BITS];
	logic [DIV_BITS-1:0] qy_sd  [0:DIV_BITS];

	assign v_sd[0]    = v_s0;
	assign side_sd[0] = side_s0;
	assign az_sd[0]   = az_s0;
	assign rx_sd[0]   = {2'b00, ax_s0[31:2]};
	assign ry_sd[0]   = {2'b00, ay_s0[31:2]};
	assign nbx_sd[0]  = {ax_s0[1:0], {(DIV_BITS-2){1'b0}}};
	assign nby_sd[0]  = {ay_s0[1:0], {(DIV_BITS-2){1'b0}}};
	assign qx_sd[0]   = '0;
	assign qy_sd[0]   = '0;

	for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
		logic [32:0] tx, ty;
		logic        gex, gey;
		assign tx  = {rx_sd[k], nbx_sd[k][DIV_BITS-1]};
		assign ty  = {ry_sd[k], nby_sd[k][DIV_BITS-1]};
		assign gex = tx >= {1'b0, az_sd[k]};
		assign gey = ty >= {1'b0, az_sd[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sd[k+1] <= 1'b0;
			end else begin
				v_sd[k+1] <= v_sd[k];
			end
		end

		always_ff @(posedge clk) begin
			side_sd[k+1] <= side_sd[k];
			az_sd[k+1]   <= az_sd[k];
			rx_sd[k+1]   <= gex ? 32'(tx - {1'b0, az_sd[k]}) : tx[31:0];
			ry_sd[k+1]   <= gey ? 32'(ty - {1'b0, az_sd[k]}) : ty[31:0];
			nbx_sd[k+1]  <= {nbx_sd[k][DIV_BITS-2:0], 1'b0};
			nby_sd[k+1]  <= {nby_sd[k][DIV_BITS-2:0], 1'b0};
			qx_sd[k+1]   <= {qx_sd[k][DIV_BITS-2:0], gex};
			qy_sd[k+1]   <= {qy_sd[k][DIV_BITS-2:0], gey};
		end
	end

	// normalize stage: clamp and sign
	logic [29:0]        mx, my;
	logic signed [30:0] mxs, mys;
	side_t              sd_end;
	assign sd_end = side_sd[DIV_BITS];
	assign mx  = (sd_end.ovf_x || qx_sd[DIV_BITS] > NORM_LIM) ? NORM_LIM : qx_sd[DIV_BITS];
	assign my  = (sd_end.ovf_y || qy_sd[DIV_BITS] > NORM_LIM) ? NORM_LIM : qy_sd[DIV_BITS];
	assign mxs = $signed({1'b0, mx});
	assign mys = $signed({1'b0, my});

	logic               v_sn;
	side_t              side_sn;
	logic signed [30:0] nx_sn, ny_sn;

	// post-divide stages
	logic [9:1]         v_s;
	side_t              side_s [1:9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sn <= 1'b0;
			v_s  <= '0;
		end else begin
			v_sn <= v_sd[DIV_BITS];
			v_s  <= {v_s[8:1], v_sn};
		end
	end

	logic signed [30:0] nx_s1, ny_s1, nx_s2, ny_s2, nx_s3, ny_s3, nx_s4, ny_s4, nx_s5, ny_s5;
	logic signed [61:0] sqx_s1, sqy_s1, nxy_s1;
	logic signed [32:0] r2_s2;
	logic signed [31:0] nxy_s2, mxx_s2, myy_s2;
	logic signed [65:0] r2sq_s3;
	logic signed [64:0] kar2_s3;
	logic signed [63:0] t1x_s3, t1y_s3;
	logic signed [33:0] tx_s3, ty_s3;
	logic signed [67:0] kbr4_s4;
	logic signed [35:0] kar2_s4, t1x_s4, t1y_s4;
	logic signed [65:0] wx_s4, wy_s4;
	logic signed [40:0] c_s5;
	logic signed [35:0] t1x_s5, t1y_s5, t1x_s6, t1y_s6;
	logic signed [37:0] wx_s5, wy_s5, wx_s6, wy_s6;
	logic signed [43:0] nch_s6, nych_s6;
	logic signed [59:0] ncl_s6, nycl_s6;
	logic signed [45:0] xd_s7, yd_s7;
	logic signed [49:0] fhx_s8, fhy_s8;
	logic signed [60:0] flx_s8, fly_s8;

	logic signed [62:0] r2sum;
	logic signed [35:0] r4;
	logic signed [12:0] c_hi;
	logic signed [28:0] c_lo;
	logic signed [17:0] xh, yh;
	logic signed [28:0] xl, yl;
	logic signed [31:0] fxs, fys;
	logic signed [51:0] su, sv;

	assign r2sum = 63'(sqx_s1) + 63'(sqy_s1);
	assign r4    = $signed(r2sq_s3[63:28]);
	assign c_hi  = $signed(c_s5[40:28]);
	assign c_lo  = $signed({1'b0, c_s5[27:0]});
	assign xh    = $signed(xd_s7[45:28]);
	assign yh    = $signed(yd_s7[45:28]);
	assign xl    = $signed({1'b0, xd_s7[27:0]});
	assign yl    = $signed({1'b0, yd_s7[27:0]});
	assign fxs   = $signed({1'b0, focal_x_q});
	assign fys   = $signed({1'b0, focal_y_q});
	assign su    = 52'(fhx_s8) + 52'($signed(flx_s8[60:28])) + 52'(center_x_q);
	assign sv    = 52'(fhy_s8) + 52'($signed(fly_s8[60:28])) + 52'(center_y_q);

	always_ff @(posedge clk) begin
		side_sn <= sd_end;
		nx_sn   <= sd_end.neg_x ? -mxs : mxs;
		ny_sn   <= sd_end.neg_y ? -mys : mys;

		side_s[1] <= side_sn;
		for (int i = 2; i <= 9; i++) begin
			side_s[i] <= side_s[i-1];
		end

		nx_s1  <= nx_sn;
		ny_s1  <= ny_sn;
		sqx_s1 <= nx_sn * nx_sn;
		sqy_s1 <= ny_sn * ny_sn;
		nxy_s1 <= nx_sn * ny_sn;

		nx_s2  <= nx_s1;
		ny_s2  <= ny_s1;
		r2_s2  <= $signed(r2sum[60:28]);
		nxy_s2 <= $signed(nxy_s1[59:28]);
		mxx_s2 <= $signed(sqx_s1[59:28]);
		myy_s2 <= $signed(sqy_s1[59:28]);

		nx_s3   <= nx_s2;
		ny_s3   <= ny_s2;
		r2sq_s3 <= r2_s2 * r2_s2;
		kar2_s3 <= radial_a_q * r2_s2;
		t1x_s3  <= nxy_s2 * tang_a_q;
		t1y_s3  <= nxy_s2 * tang_b_q;
		tx_s3   <= 34'(r2_s2) + 34'(mxx_s2) + 34'(mxx_s2);
		ty_s3   <= 34'(r2_s2) + 34'(myy_s2) + 34'(myy_s2);

		nx_s4   <= nx_s3;
		ny_s4   <= ny_s3;
		kbr4_s4 <= radial_b_q * r4;
		kar2_s4 <= $signed(kar2_s3[63:28]);
		t1x_s4  <= $signed(t1x_s3[63:28]);
		t1y_s4  <= $signed(t1y_s3[63:28]);
		wx_s4   <= tang_b_q * tx_s3;
		wy_s4   <= tang_a_q * ty_s3;

		nx_s5  <= nx_s4;
		ny_s5  <= ny_s4;
		c_s5   <= ONE_Q28 + 41'(kar2_s4) + 41'($signed(kbr4_s4[67:28]));
		t1x_s5 <= t1x_s4;
		t1y_s5 <= t1y_s4;
		wx_s5  <= $signed(wx_s4[65:28]);
		wy_s5  <= $signed(wy_s4[65:28]);

		nch_s6  <= nx_s5 * c_hi;
		ncl_s6  <= nx_s5 * c_lo;
		nych_s6 <= ny_s5 * c_hi;
		nycl_s6 <= ny_s5 * c_lo;
		t1x_s6  <= t1x_s5;
		t1y_s6  <= t1y_s5;
		wx_s6   <= wx_s5;
		wy_s6   <= wy_s5;

		xd_s7 <= 46'(nch_s6) + 46'($signed(ncl_s6[59:28])) + 46'(t1x_s6) + 46'(t1x_s6)
			+ 46'(wx_s6);
		yd_s7 <= 46'(nych_s6) + 46'($signed(nycl_s6[59:28])) + 46'(t1y_s6) + 46'(t1y_s6)
			+ 46'(wy_s6);

		fhx_s8 <= fxs * xh;
		flx_s8 <= fxs * xl;
		fhy_s8 <= fys * yh;
		fly_s8 <= fys * yl;
	end

	// stage 9: saturate and drive the result beat
	always_ff @(posedge clk) begin
		depth_zero  <= side_s[8].zero;
		result_last <= side_s[8].last;
		if (side_s[8].zero) begin
			pixel_u <= SAT_MAX;
			pixel_v <= SAT_MAX;
		end else begin
			pixel_u <= (su > 52'(SAT_MAX)) ? SAT_MAX :
				((su < 52'(SAT_MIN)) ? SAT_MIN : su[31:0]);
			pixel_v <= (sv > 52'(SAT_MAX)) ? SAT_MAX :
				((sv < 52'(SAT_MIN)) ? SAT_MIN : sv[31:0]);
		end
	end

	assign done = v_s[9];

endmodule

// ===== sv/ppd_checker.sv =====
// Port-level checks for the pinhole projection block, bound to its top level.
// Depends on ppd_pkg and pinhole_project_distort.
module ppd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic signed [31:0] pixel_u,
	input logic signed [31:0] pixel_v,
	input logic               depth_zero
);
	import ppd_pkg::*;

	logic [6:0] warm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_q <= '0;
		end else if (warm_q != 7'(LATENCY)) begin
			warm_q <= warm_q + 7'd1;
		end
	end

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_zero_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(done && depth_zero) |-> (pixel_u == SAT_MAX && pixel_v == SAT_MAX))
		else $error("zero depth result not saturated");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(warm_q == 7'(LATENCY)) |-> (done == $past(start && !busy, LATENCY)))
		else $error("result beat does not match start beat");

endmodule

bind pinhole_project_distort ppd_checker u_ppd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.pixel_u    (pixel_u),
	.pixel_v    (pixel_v),
	.depth_zero (depth_zero)
);

// ===== tb/pinhole_project_distort_tb.sv =====
// Testbench for pinhole_project_distort: drives points and register writes,
// predicts each pixel with a local fixed-point model and checks every result beat.
// Depends on ppd_pkg and the pinhole_project_distort RTL.
module pinhole_project_distort_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ppd_pkg::*;

	typedef struct {
		logic signed [31:0] u;
		logic signed [31:0] v;
		logic               zero;
		logic               last;
	} pixel_t;

	class projection_board;
		pixel_t pending_pixels[$];
		longint fx, fy, cx, cy, k1, k2, p1, p2;
		int     mismatches;

		function void load_defaults();
			fx = 32768000; fy = 32768000; cx = 20971520; cy = 15728640;
			k1 = 0; k2 = 0; p1 = 0; p2 = 0;
			mismatches = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [31:0] d);
			longint s;
			s = longint'($signed(d));
			case (idx)
				CFG_FOCAL_X:      fx = longint'({33'd0, d[30:0]});
				CFG_FOCAL_Y:      fy = longint'({33'd0, d[30:0]});
				CFG_CENTER_X:     cx = s;
				CFG_CENTER_Y:     cy = s;
				CFG_RADIAL_A:     k1 = s;
				CFG_RADIAL_B:     k2 = s;
				CFG_TANGENTIAL_A: p1 = s;
				CFG_TANGENTIAL_B: p2 = s;
				default: ;
			endcase
		endfunction

		function longint clip(longint a, longint lo, longint hi);
			return a < lo ? lo : (a > hi ? hi : a);
		endfunction

		// floor(a*b / 2^28), split to keep the product in 64 bits
		function longint scale_q28(longint a, longint b);
			longint hi, lo;
			hi = b >>> 28;
			lo = b - (hi <<< 28);
			return a * hi + ((a * lo) >>> 28);
		endfunction

		function void note_point(logic signed [31:0] px, logic signed [31:0] py,
				logic signed [31:0] pz, logic lst);
			pixel_t e;
			longint x, y, z, nx, ny, r2, r4, c, nxny, xd, yd;
			x = longint'(px); y = longint'(py); z = longint'(pz);
			e.last = lst;
			if (z == 0) begin
				e.u = SAT_MAX; e.v = SAT_MAX; e.zero = 1'b1;
			end else begin
				nx = clip((x <<< 28) / z, -536870912, 536870912);
				ny = clip((y <<< 28) / z, -536870912, 536870912);
				r2 = (nx * nx + ny * ny) >>> 28;
				r4 = scale_q28(r2, r2);
				c = 268435456 + scale_q28(k1, r2) + scale_q28(k2, r4);
				nxny = scale_q28(nx, ny);
				xd = scale_q28(nx, c) + 2 * scale_q28(nxny, p1)
					+ scale_q28(p2, r2 + 2 * scale_q28(nx, nx));
				yd = scale_q28(ny, c) + 2 * scale_q28(nxny, p2)
					+ scale_q28(p1, r2 + 2 * scale_q28(ny, ny));
				e.u = 32'(clip(scale_q28(fx, xd) + cx, longint'(SAT_MIN),
					longint'(SAT_MAX)));
				e.v = 32'(clip(scale_q28(fy, yd) + cy, longint'(SAT_MIN),
					longint'(SAT_MAX)));
				e.zero = 1'b0;
			end
			pending_pixels.push_back(e);
		endfunction

		function void check_pixel(pixel_t got);
			pixel_t e;
			if (pending_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat u=%h v=%h", got.u, got.v);
				return;
			end
			e = pending_pixels.pop_front();
			if (got.u !== e.u || got.v !== e.v || got.zero !== e.zero ||
					got.last !== e.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp u=%h v=%h z=%b l=%b got u=%h v=%h z=%b l=%b",
						e.u, e.v, e.zero, e.last, got.u, got.v, got.zero, got.last);
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic signed [31:0] point_x = '0, point_y = '0, point_z = '0;
	logic               point_last = 1'b0;
	logic               cfg_we = 1'b0;
	cfg_reg_t           cfg_index = CFG_FOCAL_X;
	logic [31:0]        cfg_data = '0;
	logic               done;
	logic signed [31:0] pixel_u, pixel_v;
	logic               depth_zero, result_last;

	projection_board board = new();
	bit              calm;

	pinhole_project_distort i_dut (.*);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		pixel_t got;
		if (arst_n) begin
			if (cfg_we)
				board.write_reg(cfg_index, cfg_data);
			if (start && !busy)
				board.note_point(point_x, point_y, point_z, point_last);
			if (done) begin
				got.u = pixel_u; got.v = pixel_v;
				got.zero = depth_zero; got.last = result_last;
				board.check_pixel(got);
			end
		end
	end

	initial begin
		#5ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	function int idle_len();
		int r;
		r = $urandom_range(0, 19);
		if (calm || r < 12)
			return 0;
		if (r < 18)
			return $urandom_range(1, 3);
		return $urandom_range(10, 45);
	endfunction

	task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic l);
		int gap;
		start <= 1'b1;
		point_x <= x; point_y <= y; point_z <= z; point_last <= l;
		do @(posedge clk); while (busy);
		gap = idle_len();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (board.pending_pixels.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic program_regs(logic [31:0] vals[8]);
		drain();
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= cfg_reg_t'(i);
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// mostly points in front of the lens with modest angles, some raw noise
	task automatic send_random(int n, int zero_odds);
		logic [31:0] x, y, z;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					x = $urandom(); y = $urandom(); z = $urandom();
				end
				default: begin
					z = $urandom_range(32'h0001_0000, 32'h0400_0000);
					if ($urandom_range(0, 7) == 0)
						z = -z;
					x = $urandom_range(0, z[31] ? -z : z);
					y = $urandom_range(0, z[31] ? -z : z);
					if ($urandom_range(0, 1)) x = -x;
					if ($urandom_range(0, 1)) y = -y;
				end
			endcase
			if ($urandom_range(0, 99) < zero_odds)
				z = '0;
			send_point(x, y, z, $urandom_range(0, 1));
		end
	endtask

	function logic [31:0] coef(int span);
		logic [31:0] m;
		m = $urandom_range(0, span);
		return $urandom_range(0, 1) ? -m : m;
	endfunction

	initial begin
		logic [31:0] regs[8];
		board.load_defaults();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		calm = 1'b1;
		send_point(32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 1'b0);
		send_point(32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 1'b1);
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b0);
		send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
		send_point(32'h0005_0000, 32'hFFFB_0000, 32'h0000_0000, 1'b1);
		send_point(32'h0003_0000, 32'h0002_0000, 32'hFFFF_0000, 1'b0);
		send_point(32'h0003_0000, 32'hFFFE_0000, 32'hFFFF_FFFF, 1'b0);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
		send_point(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		send_point(32'h0002_0000, 32'h0002_0000, 32'h0001_0000, 1'b1);

		regs = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
		program_regs(regs);
		send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0);
		send_point(32'hFFFF_0000, 32'h0000_8000, 32'h0001_0000, 1'b1);
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b0);
		send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);

		regs = '{32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
		program_regs(regs);
		send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000, 1'b1);
		send_point(32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 1'b0);
		send_point(32'h0001_2345, 32'h0000_4321, 32'h0003_0000, 1'b1);
		calm = 1'b0;
		send_random(60, 5);

		for (int ph = 0; ph < 6; ph++) begin
			regs[0] = $urandom_range(32'h0010_0000, 32'h0800_0000);
			regs[1] = $urandom_range(32'h0010_0000, 32'h0800_0000);
			regs[2] = $urandom_range(0, 32'h0400_0000);
			regs[3] = $urandom_range(0, 32'h0400_0000);
			regs[4] = coef(ph[0] ? 32'h7FFF_FFFF : 32'h0800_0000);
			regs[5] = coef(ph[0] ? 32'h7FFF_FFFF : 32'h0400_0000);
			regs[6] = coef(ph[0] ? 32'h7FFF_FFFF : 32'h0040_0000);
			regs[7] = coef(ph[0] ? 32'h7FFF_FFFF : 32'h0040_0000);
			if (ph == 5)
				regs = '{$urandom(), $urandom(), $urandom(), $urandom(),
					$urandom(), $urandom(), $urandom(), $urandom()};
			program_regs(regs);
			calm = (ph == 2);
			send_random(120, 3);
			// hold until the pipe is empty, then resume mid-phase
			drain();
			send_random(120, 3);
		end

		drain();
		if (board.mismatches == 0 && board.pending_pixels.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

// ===== filelist.f =====
sv/ppd_pkg.sv
sv/pinhole_project_distort.sv
sv/ppd_checker.sv
tb/pinhole_project_distort_tb.sv
